>>> sv/abp_pkg.sv
// Shared types, codes and arithmetic helpers for the alpha blend pixel compositor.
// Depends on nothing; the compositor top level imports it.
package abp_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (word address divided by four).
    localparam logic [1:0] REG_SRC_FMT = 2'd0;
    localparam logic [1:0] REG_DST_FMT = 2'd1;
    localparam logic [1:0] REG_TINT    = 2'd2;

    // Source formats.
    localparam logic [1:0] SRC_ARGB8888 = 2'd0;
    localparam logic [1:0] SRC_A8       = 2'd1;
    localparam logic [1:0] SRC_RGB565   = 2'd2;

    // Destination formats.
    localparam logic [1:0] DST_ARGB8888 = 2'd0;
    localparam logic [1:0] DST_A8       = 2'd1;
    localparam logic [1:0] DST_RGB565   = 2'd2;

    localparam logic [15:0] TINT_RESET = 16'hFFFF;

    // Reciprocal of 255 scaled by 2^25; exact for dividends below 132623.
    localparam logic [17:0] RECIP255   = 18'd131587;
    localparam int          RECIP_SHFT = 25;

    typedef struct packed {
        logic [31:0] source_pixel;
        logic [31:0] dest_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] blended_pixel;
        logic        write_enable;
    } pix_out_t;

    // RGB565 to 0xRRGGBB with zero low bits.
    function automatic logic [23:0] widen565_plain(input logic [15:0] c);
        return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

    // Division by 255 through the scaled reciprocal; the quotient fits eight bits here.
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP255);
        return p[RECIP_SHFT+7:RECIP_SHFT];
    endfunction

endpackage

>>> sv/alpha_blend_pixel_compositor.sv
// An accepted word passes the decode, product, division and divider registers, then the output register.
// Throughput: one pixel per cycle; the three channel divisions by output alpha take
// four stages of two quotient bits each, and a stall at the output holds every stage.
// Reset clears the valid bits and restores the format and tint registers.
// Top level of the compositor: decode, blend products, reciprocal division, divider.
// Depends on abp_pkg.
module alpha_blend_pixel_compositor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  abp_pkg::pix_in_t           pixel,
    output logic                       result_valid,
    input  logic                       result_stall,
    output abp_pkg::pix_out_t          result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [abp_pkg::APB_AW-1:0] paddr,
    input  logic [abp_pkg::APB_DW-1:0] pwdata,
    output logic [abp_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import abp_pkg::*;

    localparam int DIV_STAGES = 4;
    localparam int NSTAGE     = DIV_STAGES + 5;

    typedef struct packed {
        logic        we;
        logic [7:0]  a;
        logic [2:0][7:0] rgb;
        logic [31:0] dp;
    } s1_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  a;
        logic [31:0] dp;
        logic [2:0][15:0] sa;
        logic [2:0][16:0] sum565;
        logic [15:0] dna;
    } s2_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  a;
        logic [31:0] dp;
        logic [2:0][15:0] sa;
        logic [2:0][7:0]  q565;
        logic [7:0]  inv;
    } s3_t;

    typedef struct packed {
        logic        we;
        logic [31:0] dp;
        logic [7:0]  oa;
        logic [2:0][15:0] rem;
        logic [2:0][7:0]  q;
        logic [15:0] res565;
    } div_t;

    logic [1:0]  src_fmt_reg;
    logic [1:0]  dst_fmt_reg;
    logic [15:0] tint_reg;

    logic [NSTAGE-1:0] vld_reg;
    logic              en;

    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    s3_t      s3_reg, s3_next;
    div_t     div_reg  [0:DIV_STAGES];
    div_t     div_next [0:DIV_STAGES];
    pix_out_t out_reg, out_next;

    logic [7:0] dr565, dg565, db565;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= SRC_ARGB8888;
            dst_fmt_reg <= DST_ARGB8888;
            tint_reg    <= TINT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_SRC_FMT: src_fmt_reg <= pwdata[1:0];
                REG_DST_FMT: dst_fmt_reg <= pwdata[1:0];
                REG_TINT:    tint_reg    <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SRC_FMT: prdata = {30'd0, src_fmt_reg};
            REG_DST_FMT: prdata = {30'd0, dst_fmt_reg};
            REG_TINT:    prdata = {16'd0, tint_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // The whole pipeline advances unless a finished word waits at a stalled output.
    assign en           = !(vld_reg[NSTAGE-1] && result_stall);
    assign pixel_stall  = !en;
    assign result_valid = vld_reg[NSTAGE-1];
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], pixel_valid};
        end
    end

    // ---------------- stage 1: source decode ----------------
    always_comb
    begin
        s1_next    = '0;
        s1_next.dp = pixel.dest_pixel;
        case (src_fmt_reg)
            SRC_ARGB8888:
            begin
                s1_next.a   = pixel.source_pixel[31:24];
                s1_next.rgb = pixel.source_pixel[23:0];
            end
            SRC_A8:
            begin
                s1_next.a   = pixel.source_pixel[7:0];
                s1_next.rgb = widen565_plain(tint_reg);
            end
            default:
            begin
                s1_next.a   = 8'hFF;
                s1_next.rgb = widen565_plain(pixel.source_pixel[15:0]);
            end
        endcase
        s1_next.we = (s1_next.a != 8'd0);
    end

    // ---------------- stage 2: products ----------------
    assign dr565 = {s1_reg.dp[15:11], s1_reg.dp[15:13]};
    assign dg565 = {s1_reg.dp[10:5], s1_reg.dp[10:9]};
    assign db565 = {s1_reg.dp[4:0], s1_reg.dp[4:2]};

    always_comb
    begin
        logic [7:0] ia;
        logic [7:0] d8;
        ia         = ~s1_reg.a;
        d8         = (dst_fmt_reg == DST_A8) ? s1_reg.dp[7:0] : s1_reg.dp[31:24];
        s2_next.we = s1_reg.we;
        s2_next.a  = s1_reg.a;
        s2_next.dp = s1_reg.dp;
        for (int c = 0; c < 3; c++)
        begin
            s2_next.sa[c] = 16'(s1_reg.rgb[c]) * 16'(s1_reg.a);
        end
        s2_next.sum565[2] = 17'(s2_next.sa[2]) + 17'(16'(dr565) * 16'(ia)) + 17'd127;
        s2_next.sum565[1] = 17'(s2_next.sa[1]) + 17'(16'(dg565) * 16'(ia)) + 17'd127;
        s2_next.sum565[0] = 17'(s2_next.sa[0]) + 17'(16'(db565) * 16'(ia)) + 17'd127;
        s2_next.dna       = 16'(d8) * 16'(ia);
    end

    // ---------------- stage 3: divisions by 255 ----------------
    always_comb
    begin
        s3_next.we  = s2_reg.we;
        s3_next.a   = s2_reg.a;
        s3_next.dp  = s2_reg.dp;
        s3_next.sa  = s2_reg.sa;
        for (int c = 0; c < 3; c++)
        begin
            s3_next.q565[c] = div255(s2_reg.sum565[c]);
        end
        s3_next.inv = div255({1'b0, s2_reg.dna});
    end

    // ---------------- stage 4 and divider ----------------
    // Stage 4 forms the output alpha and colour numerators; the divider stages
    // then take two restoring steps each. The numerator never exceeds 255 times
    // the output alpha, so eight quotient bits suffice and no clamp is needed.
    always_comb
    begin
        logic [15:0] dsh;
        logic [2:0]  bitpos;
        div_next[0].we  = s3_reg.we;
        div_next[0].dp  = s3_reg.dp;
        div_next[0].oa  = s3_reg.a + s3_reg.inv;
        div_next[0].q   = '0;
        for (int c = 0; c < 3; c++)
        begin
            div_next[0].rem[c] = 16'(17'(s3_reg.sa[c])
                + 17'(16'(s3_reg.dp[8*c +: 8]) * 16'(s3_reg.inv)));
        end
        div_next[0].res565 = {s3_reg.q565[2][7:3], s3_reg.q565[1][7:2], s3_reg.q565[0][7:3]};
        for (int j = 1; j <= DIV_STAGES; j++)
        begin
            div_next[j] = div_reg[j-1];
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    bitpos = 3'(7 - 2*(j-1) - k);
                    dsh    = 16'(div_reg[j-1].oa) << bitpos;
                    if (div_next[j].rem[c] >= dsh)
                    begin
                        div_next[j].rem[c]         = div_next[j].rem[c] - dsh;
                        div_next[j].q[c][bitpos]   = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------- output word ----------------
    always_comb
    begin
        out_next.write_enable = div_reg[DIV_STAGES].we;
        if (!div_reg[DIV_STAGES].we)
        begin
            out_next.blended_pixel = div_reg[DIV_STAGES].dp;
        end
        else
        begin
            case (dst_fmt_reg)
                DST_RGB565: out_next.blended_pixel = {16'd0, div_reg[DIV_STAGES].res565};
                DST_A8:     out_next.blended_pixel = {24'd0, div_reg[DIV_STAGES].oa};
                default:    out_next.blended_pixel = {div_reg[DIV_STAGES].oa,
                                                      div_reg[DIV_STAGES].q[2],
                                                      div_reg[DIV_STAGES].q[1],
                                                      div_reg[DIV_STAGES].q[0]};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            for (int j = 0; j <= DIV_STAGES; j++)
            begin
                div_reg[j] <= div_next[j];
            end
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // A written pixel always has a nonzero output alpha to divide by.
    a_oa_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && div_reg[0].we) |-> (div_reg[0].oa != 8'd0))
        else $error("written pixel reached the divider with zero output alpha");

    // After the last divider stage every remainder lies below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NSTAGE-2] && div_reg[DIV_STAGES].we) |->
        (div_reg[DIV_STAGES].rem[0] < 16'(div_reg[DIV_STAGES].oa)
         && div_reg[DIV_STAGES].rem[1] < 16'(div_reg[DIV_STAGES].oa)
         && div_reg[DIV_STAGES].rem[2] < 16'(div_reg[DIV_STAGES].oa)))
        else $error("divider remainder not below output alpha");

    // While the pipeline is held, no valid bit moves.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule
